>>> rtl/rrb_pkg.sv
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared types and constants for the bounded rational reducer.
// ----------------------------------------------------------------------------
package rrb_pkg;

   localparam int WORD_W = 64;
   localparam int LIM_W  = 31;

   typedef struct packed {
      logic signed [63:0] numerator;
      logic signed [63:0] denominator;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_num;
      logic [30:0]        out_den;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

>>> rtl/rational_reduce_bounded.sv
// ----------------------------------------------------------------------------
// rational_reduce_bounded
// Reduces a signed 64-bit ratio to a fraction bounded by max_value.
// ----------------------------------------------------------------------------
// A request carries a signed numerator and denominator on req_valid/req_ready.
// The block strips the signs, divides by the gcd, and when the reduced pair
// exceeds max_value walks the continued fraction to the best bounded
// convergent or semiconvergent. The result leaves on rsp_valid/rsp_ready.
// All divisions run on one shared restoring divider.
// Each gcd step takes one division (up to ~93 steps), the reduction two,
// each continued fraction term one, and the final bound step up to two
// divisions plus shift-add multiplies for the semiconvergent test.
// One request is in flight; req_ready is high only while the sequencer idles.
// A finished result sits in the output register; a new request may be taken
// while it waits, and the sequencer holds its next result until rsp_ready.
// max_value is written through the csr_ port (byte address 0), reset 30000,
// and the user may change it only while no request is in flight; the block does not enforce this.
// Reset (synchronous) returns the sequencer to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
module rational_reduce_bounded (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rrb_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rrb_pkg::rsp_type  rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import rrb_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_GCD    = 5'd1;
   localparam logic [4:0] S_GCD_W  = 5'd2;
   localparam logic [4:0] S_DIVN_W = 5'd3;
   localparam logic [4:0] S_DIVD_W = 5'd4;
   localparam logic [4:0] S_CHECK  = 5'd5;
   localparam logic [4:0] S_CF     = 5'd6;
   localparam logic [4:0] S_CF_W   = 5'd7;
   localparam logic [4:0] S_MP     = 5'd8;
   localparam logic [4:0] S_MQ     = 5'd9;
   localparam logic [4:0] S_CMPQ   = 5'd10;
   localparam logic [4:0] S_LIMP   = 5'd11;
   localparam logic [4:0] S_LIMP_W = 5'd12;
   localparam logic [4:0] S_LIMQ   = 5'd13;
   localparam logic [4:0] S_LIMQ_W = 5'd14;
   localparam logic [4:0] S_TMUL   = 5'd15;
   localparam logic [4:0] S_TSUM   = 5'd16;
   localparam logic [4:0] S_MULA   = 5'd17;
   localparam logic [4:0] S_MULB   = 5'd18;
   localparam logic [4:0] S_UPDP   = 5'd19;
   localparam logic [4:0] S_UPDQ   = 5'd20;
   localparam logic [4:0] S_UPDQ2  = 5'd21;
   localparam logic [4:0] S_DONE   = 5'd22;

   localparam logic [30:0] MAX_VALUE_RESET = 31'd30000;

   logic [4:0]        state_ff, state_in;
   logic [30:0]       max_value_ff, max_value_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [63:0]       a_ff, a_in, b_ff, b_in;
   logic [63:0]       num_ff, num_in, den_ff, den_in;
   logic [63:0]       x_ff, x_in, rem_ff, rem_in;
   logic [30:0]       p0_ff, p0_in, p1_ff, p1_in, q0_ff, q0_in, q1_ff, q1_in;
   logic              neg_ff, neg_in;
   logic [62:0]       prod_ff, prod_in;
   logic              big_ff, big_in;
   logic              overp_ff, overp_in;
   logic [30:0]       sump_ff, sump_in;
   logic [33:0]       t_ff, t_in;
   logic [97:0]       acc_ff, acc_in, lhs_ff, lhs_in;
   logic [5:0]        cnt_ff, cnt_in;

   logic              div_start;
   logic [63:0]       div_a, div_b, div_q, div_r;
   div_stat_type      div_stat;
   logic [31:0]       mul_a;
   logic [30:0]       mul_b;
   logic [62:0]       mul_y;
   logic [63:0]       sum_w;
   logic              over_w;
   logic [97:0]       acc_step;
   logic [63:0]       lim_w;
   logic              csr_wr;

   rrb_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .stat      (div_stat),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign lim_w = {33'd0, max_value_ff};
   assign mul_y = mul_a * mul_b;
   // base plus stored product against the bound
   always_comb begin
      sum_w  = {1'b0, prod_ff} + {33'd0, (state_ff == S_MQ) ? p0_ff : q0_ff};
      over_w = big_ff || (sum_w > lim_w);
   end

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {1'b0, max_value_ff} : 32'd0;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      max_value_in = max_value_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      a_in = a_ff;  b_in = b_ff;  num_in = num_ff;  den_in = den_ff;
      x_in = x_ff;  rem_in = rem_ff;
      p0_in = p0_ff;  p1_in = p1_ff;  q0_in = q0_ff;  q1_in = q1_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      big_in   = big_ff;
      overp_in = overp_ff;
      sump_in  = sump_ff;
      t_in     = t_ff;
      acc_in   = acc_ff;
      lhs_in   = lhs_ff;
      cnt_in   = cnt_ff;
      div_start = 1'b0;
      div_a     = num_ff;
      div_b     = den_ff;
      mul_a     = x_ff[31:0];
      mul_b     = p1_ff;
      acc_step  = {acc_ff[96:0], 1'b0};

      if (csr_wr && csr_paddr[2] == 1'b0) begin
         max_value_in = csr_pwdata[30:0];
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               num_in = req_data.numerator[63] ? (64'd0 - req_data.numerator)
                                               : req_data.numerator;
               den_in = req_data.denominator[63] ? (64'd0 - req_data.denominator)
                                                 : req_data.denominator;
               a_in   = num_in;
               b_in   = den_in;
               neg_in = req_data.numerator[63] ^ req_data.denominator[63];
               p0_in = 31'd0;  q0_in = 31'd1;  p1_in = 31'd1;  q1_in = 31'd0;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (b_ff == 64'd0) begin
               if (a_ff == 64'd0) begin
                  state_in = S_CHECK;
               end else begin
                  div_start = 1'b1;
                  div_a     = num_ff;
                  div_b     = a_ff;
                  state_in  = S_DIVN_W;
               end
            end else begin
               div_start = 1'b1;
               div_a     = a_ff;
               div_b     = b_ff;
               state_in  = S_GCD_W;
            end
         end
         S_GCD_W: begin
            if (div_stat.done) begin
               a_in     = b_ff;
               b_in     = div_r;
               state_in = S_GCD;
            end
         end
         S_DIVN_W: begin
            if (div_stat.done) begin
               num_in    = div_q;
               div_start = 1'b1;
               div_a     = den_ff;
               div_b     = a_ff;
               state_in  = S_DIVD_W;
            end
         end
         S_DIVD_W: begin
            if (div_stat.done) begin
               den_in   = div_q;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (num_ff <= lim_w && den_ff <= lim_w) begin
               p1_in    = num_ff[30:0];
               q1_in    = den_ff[30:0];
               state_in = S_DONE;
            end else begin
               state_in = S_CF;
            end
         end
         S_CF: begin
            if (den_ff == 64'd0) begin
               state_in = S_DONE;
            end else begin
               div_start = 1'b1;
               div_a     = num_ff;
               div_b     = den_ff;
               state_in  = S_CF_W;
            end
         end
         S_CF_W: begin
            if (div_stat.done) begin
               x_in     = div_q;
               rem_in   = div_r;
               state_in = S_MP;
            end
         end
         S_MP: begin
            mul_a    = x_ff[31:0];
            mul_b    = p1_ff;
            prod_in  = mul_y;
            big_in   = (x_ff[63:32] != 32'd0) && (p1_ff != 31'd0);
            state_in = S_MQ;
         end
         S_MQ: begin
            overp_in = over_w;
            sump_in  = sum_w[30:0];
            mul_a    = x_ff[31:0];
            mul_b    = q1_ff;
            prod_in  = mul_y;
            big_in   = (x_ff[63:32] != 32'd0) && (q1_ff != 31'd0);
            state_in = S_CMPQ;
         end
         S_CMPQ: begin
            if (overp_ff || over_w) begin
               state_in = S_LIMP;
            end else begin
               p0_in    = p1_ff;
               p1_in    = sump_ff;
               q0_in    = q1_ff;
               q1_in    = sum_w[30:0];
               num_in   = den_ff;
               den_in   = rem_ff;
               state_in = S_CF;
            end
         end
         S_LIMP: begin
            if (p1_ff != 31'd0) begin
               div_start = 1'b1;
               div_a     = (lim_w > {33'd0, p0_ff}) ? (lim_w - {33'd0, p0_ff}) : 64'd0;
               div_b     = {33'd0, p1_ff};
               state_in  = S_LIMP_W;
            end else begin
               state_in = S_LIMQ;
            end
         end
         S_LIMP_W: begin
            if (div_stat.done) begin
               x_in     = div_q;
               state_in = S_LIMQ;
            end
         end
         S_LIMQ: begin
            if (q1_ff != 31'd0) begin
               div_start = 1'b1;
               div_a     = (lim_w > {33'd0, q0_ff}) ? (lim_w - {33'd0, q0_ff}) : 64'd0;
               div_b     = {33'd0, q1_ff};
               state_in  = S_LIMQ_W;
            end else begin
               if (p1_ff == 31'd0) begin
                  x_in = 64'd0;
               end
               state_in = S_TMUL;
            end
         end
         S_LIMQ_W: begin
            if (div_stat.done) begin
               if (div_q < x_ff || p1_ff == 31'd0) begin
                  x_in = (div_q < x_ff) ? div_q : x_ff;
               end
               state_in = S_TMUL;
            end
         end
         S_TMUL: begin
            mul_a    = x_ff[31:0];
            mul_b    = q1_ff;
            prod_in  = mul_y;
            state_in = S_TSUM;
         end
         S_TSUM: begin
            // t = 2*x*q1 + q0, then den*t and num*q1 by shift-add
            t_in     = {prod_ff[32:0], 1'b0} + {3'd0, q0_ff};
            acc_in   = '0;
            cnt_in   = 6'd33;
            state_in = S_MULA;
         end
         S_MULA: begin
            acc_step = {acc_ff[96:0], 1'b0} + (t_ff[cnt_ff] ? {34'd0, den_ff} : 98'd0);
            acc_in   = acc_step;
            cnt_in   = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               lhs_in   = acc_step;
               acc_in   = '0;
               cnt_in   = 6'd30;
               state_in = S_MULB;
            end
         end
         S_MULB: begin
            acc_step = {acc_ff[96:0], 1'b0}
                     + (q1_ff[cnt_ff[4:0]] ? {34'd0, num_ff} : 98'd0);
            acc_in   = acc_step;
            cnt_in   = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               state_in = (lhs_ff > acc_step) ? S_UPDP : S_DONE;
            end
         end
         S_UPDP: begin
            mul_a    = x_ff[31:0];
            mul_b    = p1_ff;
            prod_in  = mul_y;
            state_in = S_UPDQ;
         end
         S_UPDQ: begin
            p1_in    = prod_ff[30:0] + p0_ff;
            mul_a    = x_ff[31:0];
            mul_b    = q1_ff;
            prod_in  = mul_y;
            state_in = S_UPDQ2;
         end
         S_UPDQ2: begin
            q1_in    = prod_ff[30:0] + q0_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.out_num = neg_ff ? (32'd0 - {1'b0, p1_ff}) : {1'b0, p1_ff};
               rsp_data_in.out_den = q1_ff;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_value_ff <= MAX_VALUE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_value_ff <= max_value_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      a_ff   <= a_in;    b_ff   <= b_in;
      num_ff <= num_in;  den_ff <= den_in;
      x_ff   <= x_in;    rem_ff <= rem_in;
      p0_ff  <= p0_in;   p1_ff  <= p1_in;
      q0_ff  <= q0_in;   q1_ff  <= q1_in;
      neg_ff   <= neg_in;
      prod_ff  <= prod_in;
      big_ff   <= big_in;
      overp_ff <= overp_in;
      sump_ff  <= sump_in;
      t_ff     <= t_in;
      acc_ff   <= acc_in;
      lhs_ff   <= lhs_in;
      cnt_ff   <= cnt_in;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sequencer still idle after taking a request");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_cf_step_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMPQ && !overp_ff && !over_w |=> p1_ff <= max_value_ff)
      else $error("convergent numerator above bound");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside done state");

endmodule

>>> rtl/rrb_divider.sv
// ----------------------------------------------------------------------------
// rrb_divider
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rrb_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [63:0]              dividend,
   input  logic [63:0]              divisor,
   output rrb_pkg::div_stat_type    stat,
   output logic [63:0]              quotient,
   output logic [63:0]              remainder
);
   import rrb_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [64:0] trial;
   logic [64:0] diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[63]};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (busy_ff) begin
         if (!diff[64]) begin
            rem_in = diff[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd63;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the bounded rational reducer. Every request is predicted in the
// scoreboard, with 128-bit products for the semiconvergent test, and each response is compared field by field.
// The bound is changed between phases of random traffic with idling and stalls.
// ----------------------------------------------------------------------------
module testbench;
   import rrb_pkg::*;

   localparam int WATCHDOG_LIMIT = 60000;
   localparam logic [2:0] MAX_VALUE_ADDR = 3'd0;

   class ratio_scoreboard;
      logic [63:0] bound;
      rsp_type     pending_q[$];
      int          errors;
      int          checked;

      function new();
         bound   = 64'd30000;
         errors  = 0;
         checked = 0;
      endfunction

      // true when base + x * step exceeds the bound
      function bit exceeds(logic [63:0] x, logic [63:0] step, logic [63:0] base);
         if (base > bound) return 1;
         if (step == 0) return 0;
         return x > (bound - base) / step;
      endfunction

      function rsp_type reduce(req_type r);
         logic [63:0]  num, den, g, a, b, t, x, rem, p0, q0, p1, q1, p2, q2;
         logic [127:0] lhs, rhs;
         logic [31:0]  mag;
         bit           neg, stop;
         rsp_type      res;
         neg = r.numerator[63] ^ r.denominator[63];
         num = r.numerator[63] ? 64'd0 - r.numerator : r.numerator;
         den = r.denominator[63] ? 64'd0 - r.denominator : r.denominator;
         p0 = 0; q0 = 1; p1 = 1; q1 = 0;
         a = num; b = den;
         while (b != 0) begin
            t = a % b; a = b; b = t;
         end
         g = a;
         if (g != 0) begin
            num = num / g;
            den = den / g;
         end
         if (num <= bound && den <= bound) begin
            p1 = num; q1 = den; den = 0;
         end
         stop = 0;
         while (den != 0 && !stop) begin
            x   = num / den;
            rem = num % den;
            if (exceeds(x, p1, p0) || exceeds(x, q1, q0)) begin
               // largest term that keeps both within the bound, then semiconvergent test
               if (p1 != 0) x = (p0 > bound ? 64'd0 : bound - p0) / p1;
               if (q1 != 0) begin
                  t = (q0 > bound ? 64'd0 : bound - q0) / q1;
                  if (t < x) x = t;
               end
               if (p1 == 0 && q1 == 0) x = 0;
               t = 2 * x * q1 + q0;
               lhs = 128'(den) * 128'(t);
               rhs = 128'(num) * 128'(q1);
               if (lhs > rhs) begin
                  p1 = x * p1 + p0;
                  q1 = x * q1 + q0;
               end
               stop = 1;
            end else begin
               p2 = x * p1 + p0;
               q2 = x * q1 + q0;
               p0 = p1; q0 = q1; p1 = p2; q1 = q2;
               num = den; den = rem;
            end
         end
         mag = p1[31:0];
         res.out_num = neg ? 32'd0 - mag : mag;
         res.out_den = q1[30:0];
         return res;
      endfunction

      function void note_request(req_type r);
         pending_q.push_back(reduce(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp_rsp;
         if (pending_q.size() == 0) begin
            $error("response with no request outstanding: %0d/%0d",
                   got.out_num, got.out_den);
            errors++;
            return;
         end
         exp_rsp = pending_q.pop_front();
         checked++;
         if (got.out_num !== exp_rsp.out_num) begin
            $error("out_num expected %0d actual %0d", exp_rsp.out_num, got.out_num);
            errors++;
         end
         if (got.out_den !== exp_rsp.out_den) begin
            $error("out_den expected %0d actual %0d", exp_rsp.out_den, got.out_den);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ratio_scoreboard sb = new();
   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   int  requests_sent = 0;
   int  quiet_cycles = 0;
   int  bounds_used = 1;

   always #2 clock = ~clock;

   rational_reduce_bounded i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // response side: checks, random stalls, and one long hold-off early on
   always @(posedge clock) begin
      int cyc;
      if (!reset) begin
         cyc++;
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if (cyc >= 300 && cyc < 3300)
            rsp_ready <= 1'b0;
         else
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("testbench failed");
         $finish;
      end
   end

   task automatic send_request(logic [63:0] n, logic [63:0] d);
      req_type r;
      r.numerator   = n;
      r.denominator = d;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      requests_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_bound(logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MAX_VALUE_ADDR;
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.bound = 64'(v[30:0]);
      bounds_used++;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand_word();
      logic [63:0] v;
      int nbits;
      nbits = $urandom_range(1, 64);
      v = {$urandom, $urandom};
      v = v >> (64 - nbits);
      if ($urandom_range(1)) v = 64'd0 - v;
      return v;
   endfunction

   task automatic random_requests(int count);
      logic [63:0] a, b, k;
      repeat (count) begin
         case ($urandom_range(3))
            0: begin
               // small fraction scaled by a common factor
               a = $urandom_range(0, 5000);
               b = $urandom_range(1, 5000);
               k = $urandom_range(1, 32'h7fffffff);
               a = a * k; b = b * k;
               if ($urandom_range(1)) a = 64'd0 - a;
               if ($urandom_range(1)) b = 64'd0 - b;
            end
            1: begin
               a = {$urandom, $urandom};
               b = {$urandom, $urandom};
            end
            default: begin
               a = rand_word();
               b = rand_word();
               if ($urandom_range(15) == 0) b = 0;
               if ($urandom_range(15) == 0) a = 0;
            end
         endcase
         send_request(a, b);
      end
   endtask

   localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero cases, extremes, sign handling, classic approximations
      send_request(0, 0);
      send_request(5, 0);
      send_request(-5, 0);
      send_request(0, 7);
      send_request(0, -7);
      send_request(MOST_NEG, 1);
      send_request(1, MOST_NEG);
      send_request(MOST_NEG, MOST_NEG);
      send_request(MOST_POS, MOST_POS);
      send_request(MOST_POS, -1);
      send_request(-MOST_POS, 3);
      send_request(1, MOST_POS);
      send_request(MOST_NEG, MOST_POS);
      send_request(355, -113);
      send_request(30000, 30001);
      send_request(30001, 30000);
      send_request(60000, 2);
      send_request(64'd314159265358979, 64'd100000000000000);
      send_request(64'd2000006, 64'd3000009);
      send_request(-64'd1, -64'd1);
      send_request(64'hffff_ffff, 64'h1_0000_0001);
      drain();

      write_bound(32'h7fff_ffff);
      send_request(MOST_NEG, 3);
      send_request(MOST_POS, 64'h7fff_fffe);
      random_requests(25);
      drain();

      write_bound(32'd1);
      send_idle_pct = 57;
      send_request(MOST_POS, 2);
      send_request(2, 5);
      random_requests(25);
      drain();

      write_bound(32'd100);
      send_idle_pct = 0;
      rsp_stall_pct = 57;
      random_requests(25);
      drain();

      write_bound($urandom_range(1, 32'h7fff_ffff));
      send_idle_pct = 9;
      rsp_stall_pct = 9;
      random_requests(25);
      drain();

      $display("%0d requests over %0d bounds, %0d responses checked",
               requests_sent, bounds_used, sb.checked);
      $display("covered zero and extreme operands, gcd reduction and bounded approximation");
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end
endmodule
